[src/rlc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rlc_pkg: shared types and constants of the nibble run-length codec
// Result status codes, the job record passed from front to back, and
// default sizing of the job queue.
// ----------------------------------------------------------------------------
package rlc_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DATA   = 2'd0,
        ST_BADSYM = 2'd1,
        ST_NOTERM = 2'd2,
        ST_DONE   = 2'd3
    } t_status;

    // Input action codes.
    localparam logic ACT_DATA = 1'b0;
    localparam logic ACT_EOS  = 1'b1;

    // Mode register codes.
    localparam logic MODE_COMPRESS   = 1'b0;
    localparam logic MODE_DECOMPRESS = 1'b1;

    localparam logic [3:0] NIB_MAX   = 4'hF;
    localparam logic [3:0] NIB_ZERO  = 4'h0;
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    // One classified item: emit rep copies of data_byte with status,
    // then optionally a 0x00 terminator as a data result.
    typedef struct packed {
        logic [7:0] data_byte;
        logic [3:0] rep;
        t_status    status;
        logic       trailer;
    } t_job;

    localparam int QUEUE_DEPTH_DEF = 2;

endpackage : rlc_pkg
`default_nettype wire

[src/nibble_run_length_codec.sv]
// An accepted item passes the job queue, job register and output register before its first result shows.
// Throughput: one item per cycle at the input while the job queue has room;
// the back end holds each job until its expansion counter has emitted one
// result per cycle into the output register, while that register is free.
// Reset (synchronous, active low) clears mode, stream state, queue and output valid flag.
`default_nettype none
// ----------------------------------------------------------------------------
// nibble_run_length_codec: run-length codec for 4-bit symbols
// Compresses symbols into value/count code bytes or expands code bytes back
// into symbols. The front classifies each item and updates the stream state,
// a short job queue decouples it from the back, which expands each job into
// results one per cycle while the output register has room.
// ----------------------------------------------------------------------------
module nibble_run_length_codec
    import rlc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Configuration: decompress_mode
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_wdata,
    // Input side
    input  wire logic       push,
    output logic            full,
    input  wire logic       i_action,
    input  wire logic [7:0] i_in_byte,
    // Result side
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_out_byte,
    output logic [1:0]      o_status,
    output logic            o_last_of_run
);

    t_job job_in;
    t_job job_out;
    logic job_push;
    logic q_full;
    logic q_empty;
    logic q_pop;

    // Front: transfer an item whenever the queue has room; items that cause
    // no result only update the stream state.
    rlc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_action    (i_action),
        .i_in_byte   (i_in_byte),
        .i_q_full    (q_full),
        .o_job       (job_in),
        .o_job_push  (job_push)
    );

    // Job queue: lets the front keep taking items while the back expands.
    rlc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (job_out),
        .o_empty (q_empty)
    );

    // Back: expand each job, one result per cycle while the output register is free, into it.
    rlc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_job         (job_out),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_out_byte    (o_out_byte),
        .o_status      (o_status),
        .o_last_of_run (o_last_of_run)
    );

    // Hold input while the queue is full.
    assign full = q_full;

`ifndef SYNTH
    // Queue flags never both set.
    a_queue_flags : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_full && q_empty))
        else $error("job queue reports full and empty at once");

    // Error and end-of-stream results carry a zero byte.
    a_status_byte : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ST_DATA) |-> (o_out_byte == BYTE_ZERO))
        else $error("non-data result with nonzero byte");

    // Error and end-of-stream results are always the last of their item.
    a_status_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ST_DATA) |-> o_last_of_run)
        else $error("non-data result not marked last");

    // A job is never taken from an empty queue.
    a_pop_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("back end popped an empty job queue");
`endif

endmodule : nibble_run_length_codec
`default_nettype wire

[src/rlc_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rlc_front: item intake and classification
// Holds the mode register and the stream state, and turns each accepted
// item into at most one job for the back end.
// ----------------------------------------------------------------------------
module rlc_front
    import rlc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_wdata,
    input  wire logic       i_push,
    input  wire logic       i_action,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_q_full,
    output t_job            o_job,
    output logic            o_job_push
);

    logic       r_mode;
    logic [3:0] r_run_value;
    logic [3:0] r_run_count;
    logic       r_halted;
    logic       r_done;

    logic [3:0] n_run_value;
    logic [3:0] n_run_count;
    logic       n_halted;
    logic       n_done;

    logic       accept;
    logic       gen;
    logic [3:0] b_lo;
    logic [3:0] b_hi;

    assign accept = i_push && !i_q_full;
    assign b_lo   = i_in_byte[3:0];
    assign b_hi   = i_in_byte[7:4];

    always_comb begin
        n_run_value     = r_run_value;
        n_run_count     = r_run_count;
        n_halted        = r_halted;
        n_done          = r_done;
        gen             = 1'b0;
        o_job.data_byte = BYTE_ZERO;
        o_job.rep       = 4'd1;
        o_job.status    = ST_DATA;
        o_job.trailer   = 1'b0;

        if (i_action == ACT_EOS) begin
            // End of stream: report unless halted (or, expanding, done), then clear the stream state.
            if (r_mode == MODE_COMPRESS) begin
                if (!r_halted) begin
                    gen = 1'b1;
                    if (r_run_count != NIB_ZERO) begin
                        o_job.data_byte = {r_run_value, r_run_count};
                        o_job.trailer   = 1'b1;
                    end
                end
            end else begin
                if (!r_halted && !r_done) begin
                    gen          = 1'b1;
                    o_job.status = ST_NOTERM;
                end
            end
            n_run_value = NIB_ZERO;
            n_run_count = NIB_ZERO;
            n_halted    = 1'b0;
            n_done      = 1'b0;
        end else if (r_mode == MODE_COMPRESS) begin
            if (!r_halted) begin
                if (b_hi != NIB_ZERO) begin
                    gen          = 1'b1;
                    o_job.status = ST_BADSYM;
                    n_halted     = 1'b1;
                end else if (b_lo == r_run_value) begin
                    if (r_run_count == NIB_MAX) begin
                        gen             = 1'b1;
                        o_job.data_byte = {r_run_value, NIB_MAX};
                        n_run_count     = 4'd1;
                    end else begin
                        n_run_count = r_run_count + 4'd1;
                    end
                end else begin
                    if (r_run_count != NIB_ZERO) begin
                        gen             = 1'b1;
                        o_job.data_byte = {r_run_value, r_run_count};
                    end
                    n_run_value = b_lo;
                    n_run_count = 4'd1;
                end
            end
        end else begin
            if (!r_halted && !r_done) begin
                if (i_in_byte == BYTE_ZERO) begin
                    gen          = 1'b1;
                    o_job.status = ST_DONE;
                    n_done       = 1'b1;
                end else if (b_lo != NIB_ZERO) begin
                    gen             = 1'b1;
                    o_job.data_byte = {NIB_ZERO, b_hi};
                    o_job.rep       = b_lo;
                end
            end
        end
    end

    assign o_job_push = accept && gen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_COMPRESS;
            r_run_value <= NIB_ZERO;
            r_run_count <= NIB_ZERO;
            r_halted    <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (accept) begin
                r_run_value <= n_run_value;
                r_run_count <= n_run_count;
                r_halted    <= n_halted;
                r_done      <= n_done;
            end
        end
    end

endmodule : rlc_front
`default_nettype wire

[src/rlc_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rlc_queue: job queue between front and back
// Small circular buffer of jobs with full and empty flags.
// ----------------------------------------------------------------------------
module rlc_queue
    import rlc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_data,
    output logic      o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule : rlc_queue
`default_nettype wire

[src/rlc_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rlc_back: job expansion and result register
// Takes one job at a time and emits its results one per cycle into an
// output register that the consumer drains, stalling while it stays full.
// ----------------------------------------------------------------------------
module rlc_back
    import rlc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_q_empty,
    input  t_job       i_job,
    output logic       o_q_pop,
    input  wire logic  i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_status,
    output logic       o_last_of_run
);

    logic [7:0] r_byte;
    logic [3:0] r_rem;
    t_status    r_status;
    logic       r_trailer;

    logic       r_ovalid;
    logic [7:0] r_obyte;
    t_status    r_ostatus;
    logic       r_olast;

    logic busy;
    logic out_free;
    logic emit;

    assign busy     = (r_rem != NIB_ZERO) || r_trailer;
    assign out_free = !r_ovalid || i_pop;
    assign emit     = busy && out_free;
    assign o_q_pop  = !busy && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem     <= NIB_ZERO;
            r_trailer <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_byte    <= i_job.data_byte;
                r_rem     <= i_job.rep;
                r_status  <= i_job.status;
                r_trailer <= i_job.trailer;
            end else if (emit) begin
                if (r_rem != NIB_ZERO) begin
                    r_rem <= r_rem - 4'd1;
                end else begin
                    r_trailer <= 1'b0;
                end
            end

            if (emit) begin
                r_ovalid <= 1'b1;
                if (r_rem != NIB_ZERO) begin
                    r_obyte   <= r_byte;
                    r_ostatus <= r_status;
                    r_olast   <= (r_rem == 4'd1) && !r_trailer;
                end else begin
                    r_obyte   <= BYTE_ZERO;
                    r_ostatus <= ST_DATA;
                    r_olast   <= 1'b1;
                end
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_empty       = !r_ovalid;
    assign o_out_byte    = r_obyte;
    assign o_status      = r_ostatus;
    assign o_last_of_run = r_olast;

endmodule : rlc_back
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for nibble_run_length_codec
// Feeds symbol streams and code-byte streams through both codec modes. A
// behavioral model of the stream state predicts every result at the moment
// the item transfers in, and a monitor compares each popped result field by
// field against the oldest prediction. Sender gaps and receiver stalls are
// varied per phase.
// ----------------------------------------------------------------------------
module testbench;
    import rlc_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int CYCLE_LIMIT   = 200000;
    // Pipeline depth plus queue slack: covers items still in flight that
    // give no result when the last predicted result has already popped.
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_GAP       = 20;

    typedef struct packed {
        logic [7:0] out_byte;
        t_status    status;
        logic       last_of_run;
    } t_codec_result;

    // DUT signals; every input starts at a known value.
    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_wdata = MODE_COMPRESS;
    logic       push        = 1'b0;
    logic       full;
    logic       i_action    = ACT_DATA;
    logic [7:0] i_in_byte   = BYTE_ZERO;
    logic       empty;
    logic       pop         = 1'b0;
    logic [7:0] o_out_byte;
    logic [1:0] o_status;
    logic       o_last_of_run;

    // Model of the codec's mode register and stream state.
    logic       mode_model;
    logic [3:0] run_val;
    logic [3:0] run_cnt;
    logic       halted_flag;
    logic       done_flag;

    // Results caused by the item currently being modeled.
    logic [7:0] burst_byte   [0:15];
    t_status    burst_status [0:15];
    int         burst_len;

    // Predicted results, oldest first.
    t_codec_result pending_out [$];
    t_codec_result head_result;

    int mismatch_count = 0;
    int live_items     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;

    nibble_run_length_codec dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .push          (push),
        .full          (full),
        .i_action      (i_action),
        .i_in_byte     (i_in_byte),
        .empty         (empty),
        .pop           (pop),
        .o_out_byte    (o_out_byte),
        .o_status      (o_status),
        .o_last_of_run (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Hard stop: count cycles and fail the run if it never finishes.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stream model
    // ------------------------------------------------------------------
    function automatic void clear_stream_model();
        run_val     = NIB_ZERO;
        run_cnt     = NIB_ZERO;
        halted_flag = 1'b0;
        done_flag   = 1'b0;
    endfunction

    function automatic void add_result(logic [7:0] ob, t_status st);
        burst_byte[burst_len]   = ob;
        burst_status[burst_len] = st;
        burst_len++;
    endfunction

    // Advance the model by one transferred item and queue its results; the
    // last result of the item carries the last_of_run flag.
    function automatic void predict_codec(logic act, logic [7:0] b);
        t_codec_result r;
        int            i;
        burst_len = 0;
        if (mode_model == MODE_COMPRESS) begin
            if (act == ACT_EOS) begin
                // Flush the open run, then the terminator, unless halted.
                if (!halted_flag) begin
                    if (run_cnt != NIB_ZERO)
                        add_result({run_val, run_cnt}, ST_DATA);
                    add_result(BYTE_ZERO, ST_DATA);
                end
                clear_stream_model();
            end else if (!halted_flag) begin
                if (b > {NIB_ZERO, NIB_MAX}) begin
                    halted_flag = 1'b1;
                    add_result(BYTE_ZERO, ST_BADSYM);
                end else if (b[3:0] == run_val) begin
                    // A sixteenth equal symbol closes a full-length code.
                    if (run_cnt == NIB_MAX) begin
                        add_result({run_val, NIB_MAX}, ST_DATA);
                        run_cnt = 4'd1;
                    end else begin
                        run_cnt = run_cnt + 4'd1;
                    end
                end else begin
                    if (run_cnt != NIB_ZERO)
                        add_result({run_val, run_cnt}, ST_DATA);
                    run_val = b[3:0];
                    run_cnt = 4'd1;
                end
            end
        end else begin
            if (act == ACT_EOS) begin
                if (!halted_flag && !done_flag)
                    add_result(BYTE_ZERO, ST_NOTERM);
                clear_stream_model();
            end else if (!halted_flag && !done_flag) begin
                if (b == BYTE_ZERO) begin
                    done_flag = 1'b1;
                    add_result(BYTE_ZERO, ST_DONE);
                end else begin
                    // Count zero expands to nothing.
                    for (i = 0; i < b[3:0]; i++)
                        add_result({NIB_ZERO, b[7:4]}, ST_DATA);
                end
            end
        end
        for (i = 0; i < burst_len; i++) begin
            r.out_byte    = burst_byte[i];
            r.status      = burst_status[i];
            r.last_of_run = (i == burst_len - 1);
            pending_out.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result monitor and receiver: compare at the edge where a result
    // transfers out, then pick pop for the next cycle.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_out.size() == 0) begin
                $error("unexpected result: out_byte %h status %0d last_of_run %b",
                       o_out_byte, o_status, o_last_of_run);
                mismatch_count++;
            end else begin
                head_result = pending_out.pop_front();
                if (o_out_byte !== head_result.out_byte) begin
                    $error("out_byte: expected %h, actual %h",
                           head_result.out_byte, o_out_byte);
                    mismatch_count++;
                end
                if (o_status !== head_result.status) begin
                    $error("status: expected %0d, actual %0d",
                           head_result.status, o_status);
                    mismatch_count++;
                end
                if (o_last_of_run !== head_result.last_of_run) begin
                    $error("last_of_run: expected %b, actual %b",
                           head_result.last_of_run, o_last_of_run);
                    mismatch_count++;
                end
            end
        end
        if (!i_rst_n)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    // Transfer one item. Push stays high on return so back-to-back items
    // need no second assignment in one step; every caller that lets time
    // pass without sending lowers push first.
    task automatic send_item(logic act, logic [7:0] b);
        int   gap;
        logic ignored;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            // Idle the input with junk on the payload.
            push      <= 1'b0;
            i_action  <= 1'($urandom_range(1));
            i_in_byte <= 8'($urandom_range(255));
            repeat (gap) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_action  <= act;
        i_in_byte <= b;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        ignored = (act == ACT_DATA) &&
                  (halted_flag || (mode_model == MODE_DECOMPRESS && done_flag));
        if (!ignored)
            live_items++;
        predict_codec(act, b);
    endtask

    // Hold the input until every predicted result has popped, then let any
    // result-free items drain through the pipeline.
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(logic m);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        mode_model  = m;
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------
    // Symbol 0 joins the reset run, then sixteen F symbols force a
    // full-length code; end of stream flushes the rest and terminates.
    task automatic test_compress_runs();
        write_mode(MODE_COMPRESS);
        send_item(ACT_DATA, 8'h00);
        repeat (16) send_item(ACT_DATA, {NIB_ZERO, NIB_MAX});
        send_item(ACT_EOS, 8'hFF);
        wait_idle();
    endtask

    // Smallest bad symbol halts the stream; data then stays ignored, also
    // after a switch to expansion, and the quiet end of stream clears.
    task automatic test_symbol_error();
        send_item(ACT_DATA, 8'h03);
        send_item(ACT_DATA, 8'h10);
        send_item(ACT_DATA, 8'h80);
        write_mode(MODE_DECOMPRESS);
        send_item(ACT_DATA, 8'h11);
        send_item(ACT_EOS, BYTE_ZERO);
        wait_idle();
    endtask

    // Longest expansion, a count-zero code, terminator, data after the
    // terminator, quiet end, then an end with no terminator.
    task automatic test_code_expansion();
        send_item(ACT_DATA, 8'hFF);
        send_item(ACT_DATA, 8'h10);
        send_item(ACT_DATA, BYTE_ZERO);
        send_item(ACT_DATA, 8'h31);
        send_item(ACT_EOS, BYTE_ZERO);
        send_item(ACT_EOS, 8'h5A);
        wait_idle();
    endtask

    // Mode flips keep the stream state: an open compress run is dropped
    // by an expansion-mode end of stream.
    task automatic test_mode_switch_mid_stream();
        send_item(ACT_DATA, 8'h23);
        write_mode(MODE_COMPRESS);
        send_item(ACT_DATA, 8'h05);
        send_item(ACT_DATA, 8'h05);
        write_mode(MODE_DECOMPRESS);
        send_item(ACT_EOS, 8'h00);
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Random streams
    // ------------------------------------------------------------------
    task automatic send_symbol_stream();
        int         len;
        int         k;
        logic [3:0] sym;
        len = $urandom_range(2, 14);
        sym = 4'($urandom_range(15));
        for (k = 0; k < len; k++) begin
            if ($urandom_range(99) < 4) begin
                send_item(ACT_DATA, 8'($urandom_range(16, 255)));
            end else begin
                if ($urandom_range(99) < 45)
                    sym = 4'($urandom_range(15));
                send_item(ACT_DATA, {NIB_ZERO, sym});
            end
        end
        // Now and then stretch a run past the longest code.
        if ($urandom_range(5) == 0)
            repeat ($urandom_range(16, 20)) send_item(ACT_DATA, {NIB_ZERO, sym});
        send_item(ACT_EOS, 8'($urandom_range(255)));
    endtask

    task automatic send_code_stream();
        int         len;
        int         k;
        logic [3:0] cnt;
        len = $urandom_range(1, 6);
        for (k = 0; k < len; k++) begin
            if ($urandom_range(99) < 10)
                cnt = NIB_ZERO;
            else if ($urandom_range(99) < 15)
                cnt = 4'($urandom_range(8, 15));
            else
                cnt = 4'($urandom_range(1, 4));
            send_item(ACT_DATA, {4'($urandom_range(15)), cnt});
        end
        if ($urandom_range(99) < 80) begin
            send_item(ACT_DATA, BYTE_ZERO);
            repeat ($urandom_range(2)) send_item(ACT_DATA, 8'($urandom_range(255)));
        end
        send_item(ACT_EOS, 8'($urandom_range(255)));
    endtask

    // Mostly well-formed streams in a random mode, some raw noise; switch
    // the mode register whenever the drawn mode differs.
    task automatic test_random_streams(int snd_pct, int rcv_pct, int quota);
        int   start;
        logic want_mode;
        send_idle_pct  = snd_pct;
        recv_stall_pct = rcv_pct;
        start = live_items;
        while (live_items - start < quota) begin
            want_mode = 1'($urandom_range(1));
            if (want_mode != mode_model)
                write_mode(want_mode);
            if ($urandom_range(99) < 10)
                repeat ($urandom_range(1, 4))
                    send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
            else if (mode_model == MODE_COMPRESS)
                send_symbol_stream();
            else
                send_code_stream();
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        mode_model = MODE_COMPRESS;
        clear_stream_model();
        // Hold reset at the start, then release it.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_compress_runs();
        test_symbol_error();
        test_code_expansion();
        test_mode_switch_mid_stream();

        live_items = 0;
        test_random_streams(0, 0, 14);
        test_random_streams(49, 0, 14);
        test_random_streams(0, 49, 14);
        test_random_streams(33, 33, 14);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule : testbench

[filelist.f]
src/rlc_pkg.sv
src/rlc_front.sv
src/rlc_queue.sv
src/rlc_back.sv
src/nibble_run_length_codec.sv
tb/testbench.sv
